// ----- rtl/core/stscan_pkg.sv -----
`default_nettype none

package stscan_pkg;

    // statement length limit and the saturating offset it implies
    localparam int MAX_STMT_LEN  = 65536;
    localparam int POS_LIMIT_INT = (MAX_STMT_LEN - 1 < 65535) ? (MAX_STMT_LEN - 1) : 65535;
    localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_INT);

    // largest integer literal value, 2^63-1
    localparam logic [62:0] NUM_MAX = '1;

    // token queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [3:0] KIND_END    = 4'd0;
    localparam logic [3:0] KIND_NUM    = 4'd1;
    localparam logic [3:0] KIND_IDENT  = 4'd2;
    localparam logic [3:0] KIND_SELECT = 4'd3;
    localparam logic [3:0] KIND_FROM   = 4'd4;
    localparam logic [3:0] KIND_WHERE  = 4'd5;
    localparam logic [3:0] KIND_AND    = 4'd6;
    localparam logic [3:0] KIND_PUNCT  = 4'd7;
    localparam logic [3:0] KIND_LE     = 4'd8;
    localparam logic [3:0] KIND_GE     = 4'd9;
    localparam logic [3:0] KIND_NE     = 4'd10;
    localparam logic [3:0] KIND_ERR    = 4'd11;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_BANG       = 2'd2;

    // keyword spellings, upper case, padded with zero
    localparam logic [2:0] KW_LEN [4] = '{3'd6, 3'd4, 3'd5, 3'd3};
    localparam logic [7:0] KW_TEXT [4][8] = '{
        '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
        '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"W", "H", "E", "R", "E", 8'h00, 8'h00, 8'h00},
        '{"A", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // one result item
    typedef struct packed {
        logic [3:0]  kind;
        logic [6:0]  punct;
        logic [62:0] value;
        logic        sat;
        logic [15:0] start;
        logic [15:0] len;
        logic [1:0]  err;
        logic        last;
    } t_token;

    // what one scanned byte hands to the token queue
    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_emit;

    // character classes
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_single_punct(input logic [7:0] c);
        return (c == "=") || (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == "%") || (c == "(") || (c == ")") || (c == ",") || (c == ";");
    endfunction

    // build a token from the given fields, with the last flag cleared
    function automatic t_token make_token(
        input logic [3:0]  kind,
        input logic [6:0]  punct,
        input logic [62:0] value,
        input logic        sat,
        input logic [15:0] start,
        input logic [15:0] len,
        input logic [1:0]  err
    );
        t_token t;
        t.kind  = kind;
        t.punct = punct;
        t.value = value;
        t.sat   = sat;
        t.start = start;
        t.len   = len;
        t.err   = err;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stscan_core.sv -----
`default_nettype none

module stscan_core import stscan_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_emit           o_emit
);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUM   = 3'd1;
    localparam logic [2:0] MODE_IDENT = 3'd2;
    localparam logic [2:0] MODE_LT    = 3'd3;
    localparam logic [2:0] MODE_GT    = 3'd4;
    localparam logic [2:0] MODE_BANG  = 3'd5;
    localparam logic [2:0] MODE_SKIP  = 3'd6;

    logic [2:0]  r_mode,  n_mode;
    logic [62:0] r_acc,   n_acc;
    logic        r_ovf,   n_ovf;
    logic [3:0]  r_cand,  n_cand;
    logic [15:0] r_start, n_start;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_pos,   n_pos;

    logic        again;
    logic        was_reset;
    logic        va;
    logic        vb;
    t_token      tok_a;
    t_token      tok_b;
    logic [66:0] acc_next;
    logic [3:0]  kw_kind;
    logic [15:0] len_grown;

    // drop keyword candidates that do not match the character at this offset
    function automatic logic [3:0] kw_track(
        input logic [3:0]  cand,
        input logic [15:0] len,
        input logic [7:0]  c
    );
        logic [7:0] up;
        logic [3:0] res;
        up  = ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
        res = cand;
        for (int k = 0; k < 4; k++) begin
            if ((len >= 16'(KW_LEN[k])) || (KW_TEXT[k][len[2:0]] != up)) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    // next state and up to two tokens for the byte in the input register
    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_cand    = r_cand;
        n_start   = r_start;
        n_len     = r_len;
        n_pos     = r_pos;
        again     = 1'b0;
        was_reset = 1'b0;
        va        = 1'b0;
        vb        = 1'b0;
        tok_a     = '0;
        tok_b     = '0;

        // acc * 10 + digit, one extra nibble shows the overflow
        acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {63'b0, i_byte[3:0]};
        len_grown = (r_len != 16'hFFFF) ? (r_len + 16'd1) : r_len;

        kw_kind = KIND_IDENT;
        for (int k = 0; k < 4; k++) begin
            if (r_cand[k] && (r_len == 16'(KW_LEN[k]))) begin
                kw_kind = KIND_SELECT + 4'(k);
            end
        end

        // continue or close the pending token
        unique case (r_mode) inside
            MODE_SKIP: begin
                if (i_byte == 8'h00) begin
                    n_mode    = MODE_IDLE;
                    n_acc     = '0;
                    n_ovf     = 1'b0;
                    n_cand    = 4'hF;
                    n_start   = '0;
                    n_len     = '0;
                    n_pos     = '0;
                    was_reset = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit(i_byte)) begin
                    if (acc_next[66:63] != 4'd0) begin
                        n_acc = NUM_MAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = acc_next[62:0];
                    end
                    n_len = len_grown;
                end else begin
                    va    = 1'b1;
                    tok_a = make_token(KIND_NUM, 7'd0, r_acc, r_ovf, r_start, r_len, ERR_NONE);
                    again = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_alpha(i_byte) || is_digit(i_byte) || (i_byte == "_")) begin
                    n_cand = kw_track(r_cand, r_len, i_byte);
                    n_len  = len_grown;
                end else begin
                    va    = 1'b1;
                    tok_a = make_token(kw_kind, 7'd0, '0, 1'b0, r_start, r_len, ERR_NONE);
                    again = 1'b1;
                end
            end
            MODE_LT, MODE_GT, MODE_BANG: begin
                va = 1'b1;
                if (i_byte == "=" || (r_mode == MODE_LT && i_byte == ">")) begin
                    if (r_mode == MODE_GT) begin
                        tok_a = make_token(KIND_GE, 7'd0, '0, 1'b0, r_start, 16'd2, ERR_NONE);
                    end else if (r_mode == MODE_LT && i_byte == "=") begin
                        tok_a = make_token(KIND_LE, 7'd0, '0, 1'b0, r_start, 16'd2, ERR_NONE);
                    end else begin
                        tok_a = make_token(KIND_NE, 7'd0, '0, 1'b0, r_start, 16'd2, ERR_NONE);
                    end
                    n_mode  = MODE_IDLE;
                    n_acc   = '0;
                    n_ovf   = 1'b0;
                    n_cand  = 4'hF;
                    n_start = '0;
                    n_len   = '0;
                end else if (r_mode == MODE_BANG) begin
                    // bang without equals: error, the byte is already discarded
                    tok_a   = make_token(KIND_ERR, 7'd0, '0, 1'b0, r_start, 16'd1, ERR_BANG);
                    n_mode  = MODE_SKIP;
                    n_acc   = '0;
                    n_ovf   = 1'b0;
                    n_cand  = 4'hF;
                    n_start = '0;
                    n_len   = '0;
                    if (i_byte == 8'h00) begin
                        n_mode    = MODE_IDLE;
                        n_pos     = '0;
                        was_reset = 1'b1;
                    end
                end else begin
                    tok_a = make_token(KIND_PUNCT, (r_mode == MODE_LT) ? 7'h3C : 7'h3E,
                                       '0, 1'b0, r_start, 16'd1, ERR_NONE);
                    again = 1'b1;
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase

        // scan the byte afresh from idle
        if (again) begin
            n_mode  = MODE_IDLE;
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_cand  = 4'hF;
            n_start = '0;
            n_len   = '0;
            if (!is_blank(i_byte)) begin
                if (i_byte == 8'h00) begin
                    vb        = 1'b1;
                    tok_b     = make_token(KIND_END, 7'd0, '0, 1'b0, r_pos, 16'd0, ERR_NONE);
                    n_pos     = '0;
                    was_reset = 1'b1;
                end else begin
                    n_start = r_pos;
                    if (is_digit(i_byte)) begin
                        n_acc  = {59'b0, i_byte[3:0]};
                        n_len  = 16'd1;
                        n_mode = MODE_NUM;
                    end else if (is_alpha(i_byte) || (i_byte == "_")) begin
                        n_cand = kw_track(4'hF, 16'd0, i_byte);
                        n_len  = 16'd1;
                        n_mode = MODE_IDENT;
                    end else if (i_byte == "<") begin
                        n_mode = MODE_LT;
                    end else if (i_byte == ">") begin
                        n_mode = MODE_GT;
                    end else if (i_byte == "!") begin
                        n_mode = MODE_BANG;
                    end else if (is_single_punct(i_byte)) begin
                        vb    = 1'b1;
                        tok_b = make_token(KIND_PUNCT, i_byte[6:0], '0, 1'b0, r_pos, 16'd1,
                                           ERR_NONE);
                    end else begin
                        vb     = 1'b1;
                        tok_b  = make_token(KIND_ERR, 7'd0, '0, 1'b0, r_pos, 16'd1,
                                            ERR_UNEXPECTED);
                        n_mode = MODE_SKIP;
                    end
                end
            end
        end

        // saturating statement offset
        if (!was_reset) begin
            n_pos = (r_pos < POS_LIMIT) ? (r_pos + 16'd1) : POS_LIMIT;
        end

        // pack for the queue
        o_emit.count       = i_step ? {va & vb, va ^ vb} : 2'd0;
        o_emit.first       = va ? tok_a : tok_b;
        o_emit.first.last  = !(va && vb);
        o_emit.second      = tok_b;
        o_emit.second.last = 1'b1;
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_cand  <= 4'hF;
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_cand  <= n_cand;
            r_start <= n_start;
            r_len   <= n_len;
            r_pos   <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stscan_queue.sv -----
`default_nettype none

module stscan_queue import stscan_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_emit i_emit,
    input  wire logic  i_pop,
    output t_token     o_head,
    output logic       o_valid,
    output logic       o_room
);

    t_token                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_cnt,    n_cnt;
    logic                  pop;
    logic [QUEUE_AW-1:0]   wr_ptr_1;

    assign o_valid  = (r_cnt != '0);
    assign o_room   = (r_cnt <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign o_head   = r_mem[r_rd_ptr];
    assign pop      = i_pop && o_valid;
    assign wr_ptr_1 = r_wr_ptr + QUEUE_AW'(1);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_AW'(i_emit.count);
        n_rd_ptr = pop ? (r_rd_ptr + QUEUE_AW'(1)) : r_rd_ptr;
        n_cnt    = r_cnt + QUEUE_CW'(i_emit.count) - QUEUE_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // token storage, up to two writes per byte
    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.first;
        end
        if (i_emit.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_emit.second;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sql_subset_token_scanner_unit.sv -----
// SQL-subset token scanner. Takes one statement byte per item on the input channel and
// delivers tokens (numbers, identifiers, the keywords SELECT/FROM/WHERE/AND, single-character
// punctuation, <= >= <> !=, end and error) on the output channel, one token per item.
// A byte is accepted every cycle while the input is not stalled; its first token reaches the
// output through the input register, then the scan logic into a four-entry token queue, and
// can be taken at the next edge. A byte can close a pending token and start a new one, giving
// two tokens, which the output side then delivers one after the other; the input stalls while
// a byte waits in the input register and the token queue has fewer than two free entries.
// Byte 0 ends a statement: the pending token, then an end token; after an error token all
// bytes up to and including the next 0 are dropped, with no end token. Number literals saturate at 2^63-1 with a flag.
`default_nettype none

module sql_subset_token_scanner_unit import stscan_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_text_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_token_kind,
    output logic [6:0]       o_punct_char,
    output logic [62:0]      o_number_value,
    output logic             o_number_saturated,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic [1:0]       o_error_code,
    output logic             o_last_of_run
);

    logic       r_in_v;
    logic [7:0] r_in_byte;
    logic       room;
    logic       step;
    logic       accept;
    t_emit      emit;
    t_token     head;

    assign step    = r_in_v && room;
    assign o_stall = r_in_v && !room;
    assign accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (accept) begin
            r_in_v <= 1'b1;
        end else if (step) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text_byte;
        end
    end

    // scan logic and scanner state
    stscan_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_emit  (emit)
    );

    // token queue feeding the output channel
    stscan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .i_pop   (!i_stall),
        .o_head  (head),
        .o_valid (o_valid),
        .o_room  (room)
    );

    assign o_token_kind       = head.kind;
    assign o_punct_char       = head.punct;
    assign o_number_value     = head.value;
    assign o_number_saturated = head.sat;
    assign o_token_start      = head.start;
    assign o_token_length     = head.len;
    assign o_error_code       = head.err;
    assign o_last_of_run      = head.last;

endmodule

`default_nettype wire

// ----- rtl/core/stscan_checker.sv -----
`default_nettype none

module stscan_checker import stscan_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [3:0]  o_token_kind,
    input wire logic [6:0]  o_punct_char,
    input wire logic [62:0] o_number_value,
    input wire logic        o_number_saturated,
    input wire logic [15:0] o_token_length,
    input wire logic [1:0]  o_error_code,
    input wire logic        o_last_of_run
);

    // a stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) && $stable(o_number_value)
                               && $stable(o_last_of_run))
        else $error("stalled token changed");

    // end token closes the byte's run and has no length
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_END |-> o_last_of_run && o_token_length == 16'd0)
        else $error("bad end token");

    // error code only on error tokens
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_token_kind == KIND_ERR) == (o_error_code != ERR_NONE)))
        else $error("error code and kind disagree");

    // saturated literal carries the maximum value
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_number_saturated |-> o_token_kind == KIND_NUM && o_number_value == NUM_MAX)
        else $error("saturated number wrong");

    // punctuation character only on punctuation tokens
    a_punct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != KIND_PUNCT |-> o_punct_char == 7'd0)
        else $error("stray punctuation character");

endmodule

bind sql_subset_token_scanner_unit stscan_checker u_stscan_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_token_kind       (o_token_kind),
    .o_punct_char       (o_punct_char),
    .o_number_value     (o_number_value),
    .o_number_saturated (o_number_saturated),
    .o_token_length     (o_token_length),
    .o_error_code       (o_error_code),
    .o_last_of_run      (o_last_of_run)
);

`default_nettype wire
